// ----- sv/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // lane order inside every per-component array and in the output word
  localparam int unsigned LANE_W = 0;
  localparam int unsigned LANE_X = 1;
  localparam int unsigned LANE_Y = 2;
  localparam int unsigned LANE_Z = 3;
  localparam int unsigned NUM_LANES = 4;

  // off-diagonal sign bits formed in the first stage
  localparam int unsigned SG_A = 0;  // m21 - m12
  localparam int unsigned SG_B = 1;  // m02 - m20
  localparam int unsigned SG_C = 2;  // m10 - m01
  localparam int unsigned SG_D = 3;  // m10 + m01
  localparam int unsigned SG_E = 4;  // m02 + m20
  localparam int unsigned SG_F = 5;  // m21 + m12
  localparam int unsigned NUM_SG = 6;

  localparam int unsigned NUM_ELEMS = 9;

endpackage

// ----- sv/rotation_matrix_to_quaternion_unit.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a 3x3 rotation matrix in signed Q2.(WORD_BITS-2) to a unit
// quaternion in the same format through a fully pipelined datapath.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ---------------------------------------
//  s_*      in   s_tvalid/s_tready  s_tdata: m00 m01 m02 m10 m11 m12 m20 m21 m22
//  m_*      out  m_tvalid/m_tready  m_tdata: q_w q_x q_y q_z
//
//  Throughput is one matrix per cycle while m_tready does not stall the
//  output. The pipeline holds two setup stages, one restoring-division stage
//  per quotient bit (2*F+3 of them), one square-root stage per root bit
//  (F+2), and the output register.
//  All stages advance together whenever the output register is empty or
//  being taken; a stall at m_tready freezes every stage, nothing is dropped.
//  rst (synchronous) clears only the valid bits of the pipeline.
//
module rotation_matrix_to_quaternion_unit
  import rmq_pkg::*;
#(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // s_tdata, low bit up: m00 m01 m02 m10 m11 m12 m20 m21 m22, zero pad
  input  logic [((NUM_ELEMS*WORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata, low bit up: q_w q_x q_y q_z, zero pad
  output logic [((NUM_LANES*WORD_BITS+7)/8)*8-1:0] m_tdata
);

  localparam int unsigned W    = WORD_BITS;
  localparam int unsigned F    = WORD_BITS - 2;
  localparam int unsigned TB   = W + 1;         // clamped candidate width
  localparam int unsigned SB   = W + 3;         // sum of four candidates
  localparam int unsigned RB   = W + 4;         // division remainder, holds 2*T
  localparam int unsigned DS   = 2 * F + 3;     // quotient bits, one per stage
  localparam int unsigned QB   = DS;
  localparam int unsigned R    = F + 2;         // root bits, one per stage
  localparam int unsigned NB   = 2 * R;         // radicand width (QB + 1)
  localparam int unsigned RMB  = R + 3;         // root remainder width
  localparam int unsigned NST  = 3 + DS + R;    // total register stages
  localparam int unsigned OUTB = ((NUM_LANES * W + 7) / 8) * 8;

  localparam logic signed [W+1:0] ONE_X = {3'b000, 1'b1, {F{1'b0}}};
  localparam logic        [W-1:0] ONE_W = {2'b01, {F{1'b0}}};

  // --------------------------------------------------------------------------
  // flow control: one enable for the whole pipeline
  // --------------------------------------------------------------------------
  logic           ce;
  logic [NST-1:0] vpipe;

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;
  assign m_tvalid = vpipe[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (ce) begin
      vpipe <= {vpipe[NST-2:0], s_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: diagonal candidates clamped at zero, off-diagonal signs
  // --------------------------------------------------------------------------
  logic signed [W-1:0] m [NUM_ELEMS];
  for (genvar e = 0; e < NUM_ELEMS; e++) begin : g_unpack
    assign m[e] = s_tdata[e*W +: W];
  end

  logic signed [W+1:0] d00, d11, d22;
  logic signed [W+1:0] traw [NUM_LANES];
  logic signed [W:0]   osum [NUM_SG];

  assign d00 = (W+2)'(m[0]);
  assign d11 = (W+2)'(m[4]);
  assign d22 = (W+2)'(m[8]);

  assign traw[LANE_W] =  d00 + d11 + d22 + ONE_X;
  assign traw[LANE_X] =  d00 - d11 - d22 + ONE_X;
  assign traw[LANE_Y] = -d00 + d11 - d22 + ONE_X;
  assign traw[LANE_Z] = -d00 - d11 + d22 + ONE_X;

  assign osum[SG_A] = (W+1)'(m[7]) - (W+1)'(m[5]);
  assign osum[SG_B] = (W+1)'(m[2]) - (W+1)'(m[6]);
  assign osum[SG_C] = (W+1)'(m[3]) - (W+1)'(m[1]);
  assign osum[SG_D] = (W+1)'(m[3]) + (W+1)'(m[1]);
  assign osum[SG_E] = (W+1)'(m[2]) + (W+1)'(m[6]);
  assign osum[SG_F] = (W+1)'(m[7]) + (W+1)'(m[5]);

  logic [TB-1:0]     t1 [NUM_LANES];
  logic [NUM_SG-1:0] sg1;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        t1[k] <= traw[k][W+1] ? '0 : traw[k][W:0];
      end
      for (int k = 0; k < NUM_SG; k++) begin
        sg1[k] <= osum[k][W];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: total, pivot and component signs
  // --------------------------------------------------------------------------
  logic [1:0]           piv;
  logic [TB-1:0]        tpiv;
  logic [NUM_LANES-1:0] negc;

  always_comb begin
    piv  = 2'(LANE_W);
    tpiv = t1[LANE_W];
    // strict compare keeps ties on the earlier component
    for (int k = 1; k < NUM_LANES; k++) begin
      if (t1[k] > tpiv) begin
        piv  = 2'(k);
        tpiv = t1[k];
      end
    end
    negc = '0;
    case (piv)
      2'(LANE_W): begin
        negc[LANE_X] = sg1[SG_A];
        negc[LANE_Y] = sg1[SG_B];
        negc[LANE_Z] = sg1[SG_C];
      end
      2'(LANE_X): begin
        negc[LANE_W] = sg1[SG_A];
        negc[LANE_Y] = sg1[SG_D];
        negc[LANE_Z] = sg1[SG_E];
      end
      2'(LANE_Y): begin
        negc[LANE_W] = sg1[SG_B];
        negc[LANE_X] = sg1[SG_D];
        negc[LANE_Z] = sg1[SG_F];
      end
      default: begin
        negc[LANE_W] = sg1[SG_C];
        negc[LANE_X] = sg1[SG_E];
        negc[LANE_Y] = sg1[SG_F];
      end
    endcase
  end

  logic [SB-1:0]        tot_sum;
  logic [TB-1:0]        t2   [NUM_LANES];
  logic [SB-1:0]        tot2;
  logic [NUM_LANES-1:0] neg2;
  logic                 zero2;

  assign tot_sum = SB'(t1[0]) + SB'(t1[1]) + SB'(t1[2]) + SB'(t1[3]);

  always_ff @(posedge clk) begin
    if (ce) begin
      t2    <= t1;
      tot2  <= tot_sum;
      neg2  <= negc;
      zero2 <= (tot_sum == '0);
    end
  end

  // --------------------------------------------------------------------------
  // restoring division t/T, one quotient bit per stage in each lane;
  // index 0 is the stage-2 output, indexes 1..DS are registers
  // --------------------------------------------------------------------------
  logic [RB-1:0]        drem [DS+1][NUM_LANES];
  logic [QB-1:0]        dquo [DS+1][NUM_LANES];
  logic [SB-1:0]        dtot [DS+1];
  logic [NUM_LANES-1:0] dneg [DS+1];
  logic                 dzero[DS+1];

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      drem[0][k] = RB'(t2[k]);
      dquo[0][k] = '0;
    end
    dtot[0]  = tot2;
    dneg[0]  = neg2;
    dzero[0] = zero2;
  end

  for (genvar j = 1; j <= DS; j++) begin : g_div
    logic [RB-1:0] shr [NUM_LANES];
    logic [RB-1:0] den;
    logic [NUM_LANES-1:0] qb;

    assign den = RB'(dtot[j-1]);

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      // first step takes the integer bit, later ones double the remainder
      if (j == 1) begin : g_first
        assign shr[k] = drem[j-1][k];
      end else begin : g_next
        assign shr[k] = {drem[j-1][k][RB-2:0], 1'b0};
      end
      assign qb[k] = (shr[k] >= den);
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        for (int k = 0; k < NUM_LANES; k++) begin
          drem[j][k] <= qb[k] ? (shr[k] - den) : shr[k];
          dquo[j][k] <= {dquo[j-1][k][QB-2:0], qb[k]};
        end
        dtot[j]  <= dtot[j-1];
        dneg[j]  <= dneg[j-1];
        dzero[j] <= dzero[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // integer square root of the quotient, one root bit per stage
  // --------------------------------------------------------------------------
  logic [NB-1:0]        srad [R+1][NUM_LANES];
  logic [RMB-1:0]       srem [R+1][NUM_LANES];
  logic [R-1:0]         sroot[R+1][NUM_LANES];
  logic [NUM_LANES-1:0] sneg [R+1];
  logic                 szero[R+1];

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      srad[0][k]  = NB'(dquo[DS][k]);
      srem[0][k]  = '0;
      sroot[0][k] = '0;
    end
    sneg[0]  = dneg[DS];
    szero[0] = dzero[DS];
  end

  for (genvar j = 1; j <= R; j++) begin : g_sqrt
    logic [RMB-1:0] rv    [NUM_LANES];
    logic [RMB-1:0] trial [NUM_LANES];
    logic [NUM_LANES-1:0] take;

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      assign rv[k]    = {srem[j-1][k][RMB-3:0], srad[j-1][k][NB-1 -: 2]};
      assign trial[k] = RMB'({sroot[j-1][k], 2'b01});
      assign take[k]  = (rv[k] >= trial[k]);
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        for (int k = 0; k < NUM_LANES; k++) begin
          srad[j][k]  <= {srad[j-1][k][NB-3:0], 2'b00};
          srem[j][k]  <= take[k] ? (rv[k] - trial[k]) : rv[k];
          sroot[j][k] <= {sroot[j-1][k][R-2:0], take[k]};
        end
        sneg[j]  <= sneg[j-1];
        szero[j] <= szero[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // output: round the doubled root to nearest, apply sign
  // --------------------------------------------------------------------------
  logic [R:0]   rnd  [NUM_LANES];
  logic [W-1:0] mag  [NUM_LANES];
  logic [W-1:0] qval [NUM_LANES];

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_out
    assign rnd[k] = (R+1)'(sroot[R][k]) + (R+1)'(1);
    assign mag[k] = W'(rnd[k][R:1]);
    always_comb begin
      if (szero[R]) begin
        qval[k] = (k == LANE_W) ? ONE_W : '0;
      end else if (sneg[R][k]) begin
        qval[k] = -mag[k];
      end else begin
        qval[k] = mag[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= OUTB'({qval[LANE_Z], qval[LANE_Y], qval[LANE_X], qval[LANE_W]});
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic signed [W-1:0] ow, ox, oy, oz;
  assign ow = m_tdata[LANE_W*W +: W];
  assign ox = m_tdata[LANE_X*W +: W];
  assign oy = m_tdata[LANE_Y*W +: W];
  assign oz = m_tdata[LANE_Z*W +: W];

  // a stalled pipeline keeps every occupied stage in place
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(vpipe))
    else $error("pipeline moved while stalled");

  // every delivered component stays within unit magnitude
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(ow) <= $signed(ONE_W)) && ($signed(ow) >= -$signed(ONE_W))
              && ($signed(ox) <= $signed(ONE_W)) && ($signed(ox) >= -$signed(ONE_W))
              && ($signed(oy) <= $signed(ONE_W)) && ($signed(oy) >= -$signed(ONE_W))
              && ($signed(oz) <= $signed(ONE_W)) && ($signed(oz) >= -$signed(ONE_W)))
    else $error("quaternion component out of range");

endmodule
